// ===== rtl/core/i2cn_pkg.sv =====
package i2cn_pkg;

    localparam int RUN_MAX = 8;
    localparam int RUN_IDX_W = 3;

    localparam logic [2:0] CS_ASCII = 3'd0;
    localparam logic [2:0] CS_GB    = 3'd1;
    localparam logic [2:0] CS_CNS1  = 3'd2;
    localparam logic [2:0] CS_CNS2  = 3'd3;

    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_MB    = 8'h24;
    localparam logic [7:0] BYTE_TO_G1 = 8'h29;
    localparam logic [7:0] BYTE_TO_G2 = 8'h2A;
    localparam logic [7:0] BYTE_SS2   = 8'h4E;
    localparam logic [7:0] BYTE_SO    = 8'h0E;
    localparam logic [7:0] BYTE_SI    = 8'h0F;
    localparam logic [7:0] FINAL_GB   = 8'h41;
    localparam logic [7:0] FINAL_CNS1 = 8'h47;
    localparam logic [7:0] FINAL_CNS2 = 8'h48;
    localparam logic [7:0] BYTE_NL    = 8'h0A;
    localparam logic [7:0] BYTE_SPACE = 8'h20;

    // one encoded run: bytes in order from index 0, last_idx = count - 1
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_IDX_W-1:0]    last_idx;
    } t_run;

endpackage

// ===== rtl/core/i2cn_if.sv =====
interface i2cn_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] char_set;
    logic [7:0] first_byte;
    logic [7:0] second_byte;

    modport source (output valid, output char_set, output first_byte,
                    output second_byte, input ready);
    modport sink (input valid, input char_set, input first_byte,
                  input second_byte, output ready);
endinterface

interface i2cn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== rtl/core/i2cn_front.sv =====
module i2cn_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    i2cn_in_if.sink          i_in,
    input  logic             i_full,
    output logic             o_push,
    output i2cn_pkg::t_run   o_run
);

    logic [1:0] r_shift_set, n_shift_set;
    logic [1:0] r_g1, n_g1;
    logic       r_g2, n_g2;
    logic [2:0] cs;
    logic [7:0] b0, b1;

    assign cs = i_in.char_set;
    assign b0 = i_in.first_byte;
    assign b1 = i_in.second_byte;
    assign i_in.ready = !i_full;
    assign o_push = i_in.valid && !i_full;

    always_comb begin
        o_run       = '0;
        n_shift_set = r_shift_set;
        n_g1        = r_g1;
        n_g2        = r_g2;
        if (cs > i2cn_pkg::CS_CNS2) begin
            o_run.bytes[0] = i2cn_pkg::BYTE_SPACE;
        end else if (cs == {1'b0, r_shift_set}) begin
            o_run.bytes[0] = b0;
            o_run.bytes[1] = b1;
            if (cs == i2cn_pkg::CS_ASCII) begin
                o_run.last_idx = 3'd0;
                if (b0 == i2cn_pkg::BYTE_NL) begin
                    n_g1 = 2'd0;
                    n_g2 = 1'b0;
                end
            end else begin
                o_run.last_idx = 3'd1;
            end
        end else begin
            case (cs)
                i2cn_pkg::CS_CNS2: begin
                    n_g2 = 1'b1;
                    if (r_g2) begin
                        o_run.bytes[0] = i2cn_pkg::BYTE_ESC;
                        o_run.bytes[1] = i2cn_pkg::BYTE_SS2;
                        o_run.bytes[2] = b0;
                        o_run.bytes[3] = b1;
                        o_run.last_idx = 3'd3;
                    end else begin
                        o_run.bytes[0] = i2cn_pkg::BYTE_ESC;
                        o_run.bytes[1] = i2cn_pkg::BYTE_MB;
                        o_run.bytes[2] = i2cn_pkg::BYTE_TO_G2;
                        o_run.bytes[3] = i2cn_pkg::FINAL_CNS2;
                        o_run.bytes[4] = i2cn_pkg::BYTE_ESC;
                        o_run.bytes[5] = i2cn_pkg::BYTE_SS2;
                        o_run.bytes[6] = b0;
                        o_run.bytes[7] = b1;
                        o_run.last_idx = 3'd7;
                    end
                end
                i2cn_pkg::CS_GB, i2cn_pkg::CS_CNS1: begin
                    n_shift_set = cs[1:0];
                    n_g1        = cs[1:0];
                    if ({1'b0, r_g1} != cs) begin
                        o_run.bytes[0] = i2cn_pkg::BYTE_ESC;
                        o_run.bytes[1] = i2cn_pkg::BYTE_MB;
                        o_run.bytes[2] = i2cn_pkg::BYTE_TO_G1;
                        o_run.bytes[3] = (cs == i2cn_pkg::CS_GB) ? i2cn_pkg::FINAL_GB
                                                                 : i2cn_pkg::FINAL_CNS1;
                        o_run.bytes[4] = i2cn_pkg::BYTE_SO;
                        o_run.bytes[5] = b0;
                        o_run.bytes[6] = b1;
                        o_run.last_idx = 3'd6;
                    end else begin
                        o_run.bytes[0] = i2cn_pkg::BYTE_SO;
                        o_run.bytes[1] = b0;
                        o_run.bytes[2] = b1;
                        o_run.last_idx = 3'd2;
                    end
                end
                default: begin
                    // back to ascii from a shifted set
                    n_shift_set    = 2'd0;
                    o_run.bytes[0] = i2cn_pkg::BYTE_SI;
                    o_run.bytes[1] = b0;
                    o_run.last_idx = 3'd1;
                    if (b0 == i2cn_pkg::BYTE_NL) begin
                        n_g1 = 2'd0;
                        n_g2 = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_set <= 2'd0;
            r_g1        <= 2'd0;
            r_g2        <= 1'b0;
        end else if (o_push) begin
            r_shift_set <= n_shift_set;
            r_g1        <= n_g1;
            r_g2        <= n_g2;
        end
    end

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shift_set != 2'd3)
        else $error("shift state out of range");
    a_g1_follows_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_shift_set != 2'd0) |-> (r_g1 == r_shift_set))
        else $error("shifted set not designated to G1");
    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_push |=> ($stable(r_shift_set) && $stable(r_g1) && $stable(r_g2)))
        else $error("state changed without an item");

endmodule

// ===== rtl/core/i2cn_queue.sv =====
module i2cn_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  i2cn_pkg::t_run   i_push_run,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output i2cn_pkg::t_run   o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    i2cn_pkg::t_run   r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");
    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

endmodule

// ===== rtl/core/i2cn_back.sv =====
module i2cn_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  i2cn_pkg::t_run   i_run,
    output logic             o_pop,
    i2cn_out_if.source       o_out
);

    logic [i2cn_pkg::RUN_IDX_W-1:0] r_idx;
    logic                           last;
    logic                           fire;

    assign last              = (r_idx == i_run.last_idx);
    assign fire              = i_valid && o_out.ready;
    assign o_pop             = fire && last;
    assign o_out.valid       = i_valid;
    assign o_out.out_byte    = i_run.bytes[r_idx];
    assign o_out.last_of_run = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (fire) begin
            r_idx <= last ? '0 : r_idx + 1'b1;
        end
    end

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (r_idx <= i_run.last_idx))
        else $error("byte index past end of run");
    a_restart_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == '0))
        else $error("index not cleared after run");
    a_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |-> (r_idx == '0))
        else $error("index set with no run pending");

endmodule

// ===== rtl/core/iso2022cn_stream_encoder_top.sv =====
// channel   dir  handshake       payload
// i_in      in   valid / ready   char_set[2:0], first_byte[7:0], second_byte[7:0]
// o_out     out  valid / ready   out_byte[7:0], last_of_run
//
// An item yields a run of 1 to 8 bytes, sent by the byte serialiser one byte per
// cycle while o_out.ready is high.
// The front accepts an item per cycle while the run queue has room.
// Reset (synchronous, low) returns to ascii with no designations, queue empty.
// A stalled output fills the queue and then drops i_in.ready.
module iso2022cn_stream_encoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cn_in_if.sink     i_in,
    i2cn_out_if.source  o_out
);

    logic           push, full, pop, empty;
    i2cn_pkg::t_run push_run, head_run;

    i2cn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_run   (push_run)
    );

    i2cn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_run (push_run),
        .o_full     (full),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_head     (head_run)
    );

    i2cn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!empty),
        .i_run   (head_run),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== test/iso2022cn_stream_encoder_top_tb.sv =====
`timescale 1ns / 100ps

module iso2022cn_stream_encoder_top_tb;

    localparam int HOLD_CYCLES = 120;
    localparam int IDLE_LIMIT  = 3000;
    localparam int TAIL_CYCLES = 24;
    localparam int SEGMENTS    = 6;
    localparam int SEG_ITEMS   = 25;

    typedef enum int {GAP_NONE, GAP_FULL, GAP_SPARSE} t_gap_mode;

    typedef struct {
        logic [2:0] char_set;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        int         gap;
        bit         wait_drain;
        bit         stall_rx;
    } t_char_item;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_enc_byte;

    logic clk;
    logic rst_n;

    i2cn_in_if  in_ch ();
    i2cn_out_if out_ch ();

    iso2022cn_stream_encoder_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_char_item pending_chars[$];
    t_enc_byte  expected_bytes[$];

    // encoder state as predicted
    logic [2:0] enc_shift;
    logic [2:0] enc_g1;
    logic       enc_g2;

    t_gap_mode  gap_mode;
    t_char_item cur_char;
    bit         char_loaded;
    int         send_gap_left;
    int         hold_asked;
    int         hold_served;
    int         hold_left;
    int         rx_wait;
    int         rx_count;
    bit         rx_burst;
    int         idle_cycles;
    int         err_count;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void encode_char(input t_char_item c);
        logic [7:0] run[$];
        bit         wide;
        wide = 1'b0;
        if (c.char_set > i2cn_pkg::CS_CNS2) begin
            run.push_back(i2cn_pkg::BYTE_SPACE);
        end else begin
            if (c.char_set == enc_shift) begin
                if (c.char_set == i2cn_pkg::CS_ASCII && c.first_byte == i2cn_pkg::BYTE_NL) begin
                    enc_g1 = i2cn_pkg::CS_ASCII;
                    enc_g2 = 1'b0;
                end
                wide = (c.char_set != i2cn_pkg::CS_ASCII);
            end else if (c.char_set == i2cn_pkg::CS_CNS2) begin
                if (!enc_g2) begin
                    run.push_back(i2cn_pkg::BYTE_ESC);
                    run.push_back(i2cn_pkg::BYTE_MB);
                    run.push_back(i2cn_pkg::BYTE_TO_G2);
                    run.push_back(i2cn_pkg::FINAL_CNS2);
                    enc_g2 = 1'b1;
                end
                run.push_back(i2cn_pkg::BYTE_ESC);
                run.push_back(i2cn_pkg::BYTE_SS2);
                wide = 1'b1;
            end else if (c.char_set == i2cn_pkg::CS_GB || c.char_set == i2cn_pkg::CS_CNS1) begin
                if (enc_g1 != c.char_set) begin
                    run.push_back(i2cn_pkg::BYTE_ESC);
                    run.push_back(i2cn_pkg::BYTE_MB);
                    run.push_back(i2cn_pkg::BYTE_TO_G1);
                    run.push_back(c.char_set == i2cn_pkg::CS_GB ? i2cn_pkg::FINAL_GB
                                                                : i2cn_pkg::FINAL_CNS1);
                    enc_g1 = c.char_set;
                end
                run.push_back(i2cn_pkg::BYTE_SO);
                enc_shift = c.char_set;
                wide = 1'b1;
            end else begin
                run.push_back(i2cn_pkg::BYTE_SI);
                if (c.first_byte == i2cn_pkg::BYTE_NL) begin
                    enc_g1 = i2cn_pkg::CS_ASCII;
                    enc_g2 = 1'b0;
                end
                enc_shift = i2cn_pkg::CS_ASCII;
            end
            run.push_back(c.first_byte);
            if (wide)
                run.push_back(c.second_byte);
        end
        foreach (run[i])
            expected_bytes.push_back('{code: run[i], last: (i == run.size() - 1)});
    endfunction

    function automatic int draw_gap();
        case (gap_mode)
            GAP_NONE: return 0;
            GAP_FULL: return $urandom_range(0, 11);
            default:  return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
        endcase
    endfunction

    function automatic void queue_char(input logic [2:0] cs, input logic [7:0] b0,
                                       input logic [7:0] b1);
        t_char_item c;
        c.char_set    = cs;
        c.first_byte  = b0;
        c.second_byte = b1;
        c.gap         = draw_gap();
        c.wait_drain  = 1'b0;
        c.stall_rx    = 1'b0;
        pending_chars.push_back(c);
    endfunction

    // mostly well-formed text: ascii runs with newlines, hanzi from each set
    function automatic void queue_random_char();
        int         r;
        logic [2:0] cs;
        logic [7:0] b0;
        r = $urandom_range(0, 99);
        if (r < 35)
            cs = i2cn_pkg::CS_ASCII;
        else if (r < 55)
            cs = i2cn_pkg::CS_GB;
        else if (r < 70)
            cs = i2cn_pkg::CS_CNS1;
        else if (r < 88)
            cs = i2cn_pkg::CS_CNS2;
        else
            cs = 3'($urandom_range(4, 7));
        b0 = 8'($urandom_range(0, 255));
        if (cs == i2cn_pkg::CS_ASCII && $urandom_range(0, 9) == 0)
            b0 = i2cn_pkg::BYTE_NL;
        queue_char(cs, b0, 8'($urandom_range(0, 255)));
    endfunction

    task automatic check_byte(input logic [7:0] code, input logic last);
        t_enc_byte want;
        if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected byte %02h last %0b", code, last));
        end else begin
            want = expected_bytes.pop_front();
            if (code !== want.code)
                report($sformatf("out_byte %02h, expected %02h", code, want.code));
            if (last !== want.last)
                report($sformatf("last_of_run %0b, expected %0b (byte %02h)",
                                 last, want.last, want.code));
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid       <= 1'b0;
            in_ch.char_set    <= i2cn_pkg::CS_ASCII;
            in_ch.first_byte  <= 8'h00;
            in_ch.second_byte <= 8'h00;
            char_loaded = 1'b0;
            send_gap_left = 0;
            enc_shift = i2cn_pkg::CS_ASCII;
            enc_g1 = i2cn_pkg::CS_ASCII;
            enc_g2 = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                encode_char(cur_char);
                char_loaded = 1'b0;
            end
            if (!char_loaded && pending_chars.size() != 0 &&
                (!pending_chars[0].wait_drain || expected_bytes.size() == 0)) begin
                cur_char = pending_chars.pop_front();
                char_loaded = 1'b1;
                send_gap_left = cur_char.gap;
                if (cur_char.stall_rx)
                    hold_asked++;
            end
            if (char_loaded && send_gap_left == 0) begin
                in_ch.valid       <= 1'b1;
                in_ch.char_set    <= cur_char.char_set;
                in_ch.first_byte  <= cur_char.first_byte;
                in_ch.second_byte <= cur_char.second_byte;
            end else begin
                in_ch.valid <= 1'b0;
                if (char_loaded)
                    send_gap_left--;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            hold_served = 0;
            hold_left = 0;
            rx_wait = 0;
            rx_count = 0;
            rx_burst = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                check_byte(out_ch.out_byte, out_ch.last_of_run);
                rx_count++;
                if (rx_count % 40 == 0)
                    rx_burst = ($urandom_range(0, 2) == 0);
                rx_wait = rx_burst ? 0 : $urandom_range(0, 11);
            end
            if (hold_served != hold_asked) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("** iso2022cn_stream_encoder_top: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.char_set    = i2cn_pkg::CS_ASCII;
        in_ch.first_byte  = 8'h00;
        in_ch.second_byte = 8'h00;
        out_ch.ready      = 1'b0;
        err_count         = 0;
        hold_asked        = 0;

        // directed: extremes, every set, designation and shift corners
        gap_mode = GAP_FULL;
        queue_char(i2cn_pkg::CS_ASCII, 8'h00, 8'hFF);
        queue_char(i2cn_pkg::CS_ASCII, 8'hFF, 8'h00);
        queue_char(i2cn_pkg::CS_ASCII, i2cn_pkg::BYTE_NL, 8'hFF);
        queue_char(i2cn_pkg::CS_GB, 8'h21, 8'h21);
        queue_char(i2cn_pkg::CS_GB, 8'hFF, 8'h00);
        queue_char(i2cn_pkg::CS_ASCII, 8'h41, 8'h00);
        queue_char(i2cn_pkg::CS_GB, 8'h00, 8'hFF);
        queue_char(i2cn_pkg::CS_CNS1, 8'h44, 8'h21);
        queue_char(i2cn_pkg::CS_CNS2, 8'h00, 8'hFF);
        queue_char(i2cn_pkg::CS_CNS2, 8'hFF, 8'h00);
        queue_char(i2cn_pkg::CS_CNS1, 8'h7E, 8'h7E);
        queue_char(i2cn_pkg::CS_ASCII, i2cn_pkg::BYTE_NL, 8'h55);
        queue_char(i2cn_pkg::CS_CNS2, 8'h21, 8'h22);
        queue_char(i2cn_pkg::CS_CNS1, 8'h30, 8'h31);
        queue_char(i2cn_pkg::CS_GB, 8'h30, 8'h31);
        queue_char(3'd4, 8'hAA, 8'h55);
        queue_char(3'd5, 8'h55, 8'hAA);
        queue_char(3'd6, 8'h0A, 8'h0A);
        queue_char(3'd7, 8'hFF, 8'hFF);
        queue_char(i2cn_pkg::CS_GB, 8'h40, 8'h41);
        queue_char(i2cn_pkg::CS_ASCII, i2cn_pkg::BYTE_NL, 8'h00);
        queue_char(i2cn_pkg::CS_ASCII, i2cn_pkg::BYTE_NL, 8'h00);
        queue_char(i2cn_pkg::CS_ASCII, 8'h7F, 8'h00);

        // receiver holds off while the sender streams back to back
        gap_mode = GAP_NONE;
        queue_random_char();
        pending_chars[pending_chars.size() - 1].wait_drain = 1'b1;
        pending_chars[pending_chars.size() - 1].stall_rx = 1'b1;
        repeat (30)
            queue_random_char();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            gap_mode = t_gap_mode'($urandom_range(0, 2));
            queue_random_char();
            if (seg == SEGMENTS / 2 || $urandom_range(0, 3) == 0)
                pending_chars[pending_chars.size() - 1].wait_drain = 1'b1;
            repeat (SEG_ITEMS - 1)
                queue_random_char();
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_chars.size() != 0 || char_loaded)
            @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("** iso2022cn_stream_encoder_top: PASSED **");
        else
            $display("** iso2022cn_stream_encoder_top: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/i2cn_pkg.sv
rtl/core/i2cn_if.sv
rtl/core/i2cn_front.sv
rtl/core/i2cn_queue.sv
rtl/core/i2cn_back.sv
rtl/core/iso2022cn_stream_encoder_top.sv
test/iso2022cn_stream_encoder_top_tb.sv
